@@ rtl/mcfs_pkg.sv @@
// Shared types, constants and score arithmetic for the motif cluster forward scorer.
// No dependencies; imported by the exp lane, the log-sum unit, the top level and the testbench.
`timescale 1ns / 1ps
package mcfs_pkg;

    typedef logic signed [31:0] score_t;
    typedef logic signed [15:0] pen_t;

    localparam score_t     MINF         = 32'sh8000_0000;
    localparam score_t     SCORE_MAX    = 32'sh7FFF_FFFF;
    localparam score_t     SCORE_START  = -32'sd4096;
    localparam int         FIELD_MOTIFS = 4;
    localparam logic [5:0] COUNT_MAX    = 6'd63;
    localparam int         DEF_MAX_MOTIFS    = 4;
    localparam int         DEF_MAX_MOTIF_LEN = 32;
    localparam int         FRAC_BITS    = 12;
    localparam logic [3:0] FRAC_LAST    = 4'd11;

    localparam logic [2:0] REG_CLUSTER_IN  = 3'd0;
    localparam logic [2:0] REG_CLUSTER_OUT = 3'd1;
    localparam logic [2:0] REG_INSIDE_STAY = 3'd2;
    localparam logic [2:0] REG_OUTSIDE_STAY = 3'd3;
    localparam logic [2:0] REG_MOTIF_COUNT = 3'd4;
    localparam logic [2:0] REG_MOTIF_PEN   = 3'd5;
    localparam logic [2:0] REG_MOTIF_LEN   = 3'd6;

    function automatic logic [15:0] exp_coef(input logic [3:0] k);
        logic [15:0] c;
        case (k)
            4'd0:    c = 16'd65525;
            4'd1:    c = 16'd65514;
            4'd2:    c = 16'd65492;
            4'd3:    c = 16'd65447;
            4'd4:    c = 16'd65359;
            4'd5:    c = 16'd65182;
            4'd6:    c = 16'd64830;
            4'd7:    c = 16'd64132;
            4'd8:    c = 16'd62757;
            4'd9:    c = 16'd60097;
            4'd10:   c = 16'd55109;
            4'd11:   c = 16'd46341;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

    function automatic score_t add_term(input score_t s, input pen_t a, input pen_t b);
        logic signed [33:0] v;
        score_t r;
        v = 34'(s) + 34'(a) + 34'(b);
        if (s == MINF || v <= -34'sd2147483648) begin
            r = MINF;
        end else if (v > 34'sd2147483647) begin
            r = SCORE_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/mcfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module mcfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mcfs_exp_lane.sv @@
// One exp2 lane: weight 2^-(base-term) in Q.16, one fraction bit per step.
// Depends on mcfs_pkg.
`timescale 1ns / 1ps
module mcfs_exp_lane
    import mcfs_pkg::*;
(
    input  logic        aclk,
    input  logic        load,
    input  logic        step,
    input  logic [3:0]  k,
    input  score_t      base,
    input  score_t      term,
    output logic [16:0] weight
);

    logic signed [32:0] d;
    logic [16:0] r_reg, r_next;
    logic [11:0] f_reg;
    logic [4:0]  sh_reg;
    logic        zero_reg;
    logic [32:0] prod;
    logic [33:0] rnd;

    assign d    = 33'(base) - 33'(term);
    assign prod = 33'(r_reg) * 33'(exp_coef(k));
    assign rnd  = 34'(prod) + 34'd32768;

    always_comb begin
        r_next = r_reg;
        if (f_reg[k]) begin
            r_next = rnd[32:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            r_reg    <= 17'd65536;
            f_reg    <= d[11:0];
            sh_reg   <= d[16:12];
            zero_reg <= (term == MINF) || (d[32:12] >= 21'd17);
        end else if (step) begin
            r_reg <= r_next;
        end
    end

    assign weight = zero_reg ? 17'd0 : (r_reg >> sh_reg);

endmodule

@@ rtl/mcfs_logsum.sv @@
// Log2-domain sum of N scores: max stage, N exp2 lanes, then a merging sum and
// a serial square-and-compare log2. Depends on mcfs_pkg and mcfs_exp_lane.
`timescale 1ns / 1ps
module mcfs_logsum
    import mcfs_pkg::*;
#(
    parameter int N = 2
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  score_t terms [N],
    output logic   busy,
    output score_t result
);

    localparam int SW = 17 + $clog2(N + 1);

    localparam logic [2:0] LS_IDLE = 3'd0;
    localparam logic [2:0] LS_MAX  = 3'd1;
    localparam logic [2:0] LS_LOAD = 3'd2;
    localparam logic [2:0] LS_EXP  = 3'd3;
    localparam logic [2:0] LS_SUM  = 3'd4;
    localparam logic [2:0] LS_NORM = 3'd5;
    localparam logic [2:0] LS_LOG  = 3'd6;
    localparam logic [2:0] LS_FIN  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    score_t      terms_reg [N];
    score_t      base_reg, base_next;
    score_t      result_reg, result_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [30:0] x_reg, x_next;
    logic [15:0] lg_reg, lg_next;
    logic [16:0] weight [N];
    logic [4:0]  msb;
    logic [4:0]  msb_off;
    logic [61:0] sq;
    logic [31:0] xs;
    logic signed [32:0] fin;

    for (genvar i = 0; i < N; i++) begin : g_lane
        mcfs_exp_lane u_lane (
            .aclk   (aclk),
            .load   (state_reg == LS_LOAD),
            .step   (state_reg == LS_EXP),
            .k      (cnt_reg),
            .base   (base_reg),
            .term   (terms_reg[i]),
            .weight (weight[i])
        );
    end

    always_comb begin
        msb = 5'd0;
        for (int b = 0; b < SW; b++) begin
            if (sum_reg[b]) begin
                msb = 5'(b);
            end
        end
    end

    assign msb_off = msb - 5'd16;
    assign sq      = 62'(x_reg) * 62'(x_reg);
    assign xs      = sq[61:30];
    assign fin     = 33'(base_reg) + 33'($signed({1'b0, lg_reg}));

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        result_next = result_reg;
        sum_next    = sum_reg;
        x_next      = x_reg;
        lg_next     = lg_reg;
        case (state_reg)
            LS_IDLE: begin
                if (start) begin
                    state_next = LS_MAX;
                end
            end
            LS_MAX: begin
                base_next = MINF;
                for (int i = 0; i < N; i++) begin
                    if (terms_reg[i] > base_next) begin
                        base_next = terms_reg[i];
                    end
                end
                state_next = LS_LOAD;
            end
            LS_LOAD: begin
                cnt_next = 4'd0;
                if (base_reg == MINF) begin
                    result_next = MINF;
                    state_next  = LS_IDLE;
                end else begin
                    state_next = LS_EXP;
                end
            end
            LS_EXP: begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == FRAC_LAST) begin
                    state_next = LS_SUM;
                end
            end
            LS_SUM: begin
                sum_next = '0;
                for (int i = 0; i < N; i++) begin
                    sum_next = sum_next + SW'(weight[i]);
                end
                state_next = LS_NORM;
            end
            LS_NORM: begin
                x_next     = 31'(sum_reg) << (5'd30 - msb);
                lg_next    = {msb_off[3:0], 12'd0};
                cnt_next   = FRAC_LAST;
                state_next = LS_LOG;
            end
            LS_LOG: begin
                if (xs[31]) begin
                    x_next           = xs[31:1];
                    lg_next[cnt_reg] = 1'b1;
                end else begin
                    x_next = xs[30:0];
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    state_next = LS_FIN;
                end
            end
            LS_FIN: begin
                result_next = (fin > 33'sd2147483647) ? SCORE_MAX : fin[31:0];
                state_next  = LS_IDLE;
            end
            default: begin
                state_next = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        result_reg <= result_next;
        sum_reg    <= sum_next;
        x_reg      <= x_next;
        lg_reg     <= lg_next;
        if (start && state_reg == LS_IDLE) begin
            terms_reg <= terms;
        end
    end

    assign busy   = (state_reg != LS_IDLE);
    assign result = result_reg;

endmodule

@@ rtl/motif_cluster_forward_score_top.sv @@
// Top level of the two-state motif cluster forward scorer: input buffer, history
// RAM, term lanes, two recurrence log-sum units and a final log-sum unit.
// Depends on mcfs_pkg, mcfs_ram and mcfs_logsum.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata (80), s_tlast
//   m_      | out | m_tvalid/m_tready  | m_tdata (32), m_tuser (1)
//   cfg_    | in  | cfg_wr_en          | cfg_index (3), cfg_wdata (64)
//
// Each position reads the history RAM once per motif (NM = min(MAX_MOTIFS, 4)), then
// runs the log-sum with twelve serial exp2 multiply steps and twelve serial log2
// squaring steps. A new word is buffered while one is in work.
// The final likelihood runs in its own log-sum unit beside the next sequence.
// Reset is synchronous, active low; no clearing pass.
// A stalled output holds the final unit and then the last position of the next run.
`timescale 1ns / 1ps
module motif_cluster_forward_score_top
    import mcfs_pkg::*;
#(
    parameter int MAX_MOTIFS    = DEF_MAX_MOTIFS,
    parameter int MAX_MOTIF_LEN = DEF_MAX_MOTIF_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bg_score, motif_score_0, motif_score_1, motif_score_2, motif_score_3
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // log_likelihood
    output logic [31:0] m_tdata,
    // underflow
    output logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam int NM  = (MAX_MOTIFS < FIELD_MOTIFS) ? MAX_MOTIFS : FIELD_MOTIFS;
    localparam int HAW = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int HD  = 2 ** HAW;
    localparam int FCW = $clog2(NM + 1);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_FETCH = 2'd1;
    localparam logic [1:0] T_TERMS = 2'd2;
    localparam logic [1:0] T_WAIT  = 2'd3;

    pen_t        cin_reg, cout_reg, istay_reg, ostay_reg;
    logic [2:0]  mcount_reg;
    logic [63:0] mpen_reg;
    logic [23:0] mlen_reg;

    logic        in_full_reg;
    logic [79:0] in_data_reg, w_data_reg;
    logic        in_last_reg, w_last_reg;

    logic [1:0]  state_reg, state_next;
    logic [FCW-1:0] fc_reg;
    score_t      inside_reg, outside_reg;
    logic [5:0]  pos_reg;
    logic [HAW-1:0] wptr_reg;
    score_t      hist_reg [NM];

    logic        fin_pend_reg;
    logic        m_valid_reg;
    score_t      m_data_reg;

    logic [HAW-1:0] raddr;
    logic [31:0] rdata;
    logic        commit;
    logic        fin_start;
    logic        out_load;
    logic        take;
    logic [5:0]  pos_inc;
    logic [3:0]  nm_eff;
    pen_t        bg;
    score_t      in_terms [NM + 2];
    score_t      out_terms [2];
    score_t      fin_terms [2];
    score_t      new_in, new_out, fin_res;
    logic        ls_in_busy, ls_out_busy, fin_busy;

    assign s_tready = !in_full_reg;
    assign take     = (state_reg == T_IDLE) && in_full_reg;
    assign bg       = $signed(w_data_reg[15:0]);
    assign pos_inc  = (pos_reg < COUNT_MAX) ? pos_reg + 6'd1 : COUNT_MAX;
    assign nm_eff   = ({1'b0, mcount_reg} > 4'(NM)) ? 4'(NM) : {1'b0, mcount_reg};

    always_comb begin
        raddr = '0;
        for (int m = 0; m < NM; m++) begin
            if (fc_reg == FCW'(m)) begin
                raddr = HAW'(wptr_reg + HAW'(1) - mlen_reg[6*m +: HAW]);
            end
        end
    end

    mcfs_ram #(
        .WIDTH (32),
        .DEPTH (HD)
    ) u_hist (
        .aclk  (aclk),
        .we    (commit),
        .waddr (wptr_reg),
        .wdata (inside_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        logic [5:0] len;
        for (int m = 0; m < NM; m++) begin
            len = mlen_reg[6*m +: 6];
            if (4'(m) < nm_eff && len != 6'd0 && len <= 6'(MAX_MOTIF_LEN) && pos_inc >= len) begin
                in_terms[m] = add_term((len == 6'd1) ? inside_reg : hist_reg[m],
                                       $signed(w_data_reg[16*(m+1) +: 16]),
                                       $signed(mpen_reg[16*m +: 16]));
            end else begin
                in_terms[m] = MINF;
            end
        end
        in_terms[NM]     = add_term(outside_reg, bg, cin_reg);
        in_terms[NM + 1] = add_term(inside_reg, bg, istay_reg);
        out_terms[0]     = add_term(outside_reg, bg, ostay_reg);
        out_terms[1]     = add_term(inside_reg, bg, cout_reg);
        fin_terms[0]     = new_in;
        fin_terms[1]     = new_out;
    end

    mcfs_logsum #(.N(NM + 2)) u_ls_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == T_TERMS),
        .terms   (in_terms),
        .busy    (ls_in_busy),
        .result  (new_in)
    );

    mcfs_logsum #(.N(2)) u_ls_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == T_TERMS),
        .terms   (out_terms),
        .busy    (ls_out_busy),
        .result  (new_out)
    );

    mcfs_logsum #(.N(2)) u_ls_fin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fin_start),
        .terms   (fin_terms),
        .busy    (fin_busy),
        .result  (fin_res)
    );

    assign commit = (state_reg == T_WAIT) && !ls_in_busy && !ls_out_busy &&
                    (!w_last_reg || (!fin_pend_reg && !fin_busy));
    assign fin_start = commit && w_last_reg;
    assign out_load  = fin_pend_reg && !fin_busy && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE: begin
                if (take) begin
                    state_next = T_FETCH;
                end
            end
            T_FETCH: begin
                if (fc_reg == FCW'(NM)) begin
                    state_next = T_TERMS;
                end
            end
            T_TERMS: begin
                state_next = T_WAIT;
            end
            T_WAIT: begin
                if (commit) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cin_reg      <= '0;
            cout_reg     <= '0;
            istay_reg    <= '0;
            ostay_reg    <= '0;
            mcount_reg   <= '0;
            mpen_reg     <= '0;
            mlen_reg     <= '0;
            in_full_reg  <= 1'b0;
            state_reg    <= T_IDLE;
            fc_reg       <= '0;
            inside_reg   <= SCORE_START;
            outside_reg  <= SCORE_START;
            pos_reg      <= '0;
            wptr_reg     <= '0;
            fin_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CLUSTER_IN:   cin_reg    <= cfg_wdata[15:0];
                    REG_CLUSTER_OUT:  cout_reg   <= cfg_wdata[15:0];
                    REG_INSIDE_STAY:  istay_reg  <= cfg_wdata[15:0];
                    REG_OUTSIDE_STAY: ostay_reg  <= cfg_wdata[15:0];
                    REG_MOTIF_COUNT:  mcount_reg <= cfg_wdata[2:0];
                    REG_MOTIF_PEN:    mpen_reg   <= cfg_wdata;
                    REG_MOTIF_LEN:    mlen_reg   <= cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                in_full_reg <= 1'b1;
            end else if (take) begin
                in_full_reg <= 1'b0;
            end
            state_reg <= state_next;
            if (state_reg == T_FETCH) begin
                fc_reg <= fc_reg + FCW'(1);
            end else begin
                fc_reg <= '0;
            end
            if (commit) begin
                wptr_reg <= wptr_reg + HAW'(1);
                if (w_last_reg) begin
                    inside_reg  <= SCORE_START;
                    outside_reg <= SCORE_START;
                    pos_reg     <= '0;
                end else begin
                    inside_reg  <= new_in;
                    outside_reg <= new_out;
                    pos_reg     <= pos_inc;
                end
            end
            if (fin_start) begin
                fin_pend_reg <= 1'b1;
            end else if (out_load) begin
                fin_pend_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (take) begin
            w_data_reg <= in_data_reg;
            w_last_reg <= in_last_reg;
        end
        for (int m = 0; m < NM; m++) begin
            if (state_reg == T_FETCH && fc_reg == FCW'(m + 1)) begin
                hist_reg[m] <= rdata;
            end
        end
        if (out_load) begin
            m_data_reg <= fin_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = (m_data_reg == MINF);

    a_fetch_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_FETCH) |-> (!ls_in_busy && !ls_out_busy))
        else $error("recurrence log-sum busy during history fetch");

    a_fin_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_start |-> (!fin_busy && !fin_pend_reg))
        else $error("final log-sum launched while occupied");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_start |=> (inside_reg == SCORE_START && outside_reg == SCORE_START && pos_reg == 6'd0))
        else $error("scores not restarted after last position");

    a_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_full_reg)
        else $error("accepted word not held in input buffer");

endmodule

@@ bench/tb_top.sv @@
// Testbench for motif_cluster_forward_score_top: drives positions over the stream
// input, predicts each sequence likelihood in the log2 domain and checks the output.
// Depends on mcfs_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
    import mcfs_pkg::*;

    typedef struct packed {
        logic signed [15:0] bg;
        logic signed [15:0] ms3;
        logic signed [15:0] ms2;
        logic signed [15:0] ms1;
        logic signed [15:0] ms0;
        logic               last;
    } pos_t;

    typedef struct {
        pos_t        p;
        logic        has_want;
        logic [31:0] want;
    } row_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;

    motif_cluster_forward_score_top DUT (.*);

    initial forever #2 aclk = ~aclk;

    // predictor state
    logic signed [63:0] pen_in, pen_out, pen_istay, pen_ostay;
    logic [2:0]  n_motifs;
    logic [63:0] m_pens;
    logic [23:0] m_lens;
    score_t      in_sc, out_sc;
    score_t      in_hist [32];
    logic [5:0]  pos_cnt;

    logic [31:0] likelihood_q[$];
    logic [31:0] fixed_q[$];
    logic        fixed_has_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 0;

    function automatic score_t sat64(logic signed [63:0] v);
        if (v <= -64'sd2147483648) return MINF;
        if (v > 64'sd2147483647) return SCORE_MAX;
        return score_t'(v);
    endfunction

    function automatic score_t sum3(score_t s, logic signed [63:0] a, logic signed [63:0] b);
        if (s == MINF) return MINF;
        return sat64(64'(s) + a + b);
    endfunction

    function automatic logic [31:0] weight(logic [63:0] d);
        logic [63:0] r;
        logic [63:0] n;
        logic [11:0] f;
        n = d >> 12;
        f = d[11:0];
        r = 65536;
        if (n >= 17) return 0;
        for (int k = 0; k < 12; k++)
            if (f[k]) r = (r * exp_coef(4'(k)) + 32768) >> 16;
        return 32'(r >> n);
    endfunction

    function automatic score_t lse(score_t t[], int n);
        score_t base;
        logic [63:0] s, x;
        int msb;
        logic signed [63:0] lg;
        base = MINF;
        s = 0;
        msb = 0;
        for (int i = 0; i < n; i++)
            if (t[i] != MINF && (base == MINF || t[i] > base)) base = t[i];
        if (base == MINF) return MINF;
        for (int i = 0; i < n; i++)
            if (t[i] != MINF) s += weight(64'(64'(base) - 64'(t[i])));
        for (int i = 0; i < 40; i++) if (s[i]) msb = i;
        x = (msb <= 30) ? (s << (30 - msb)) : (s >> (msb - 30));
        lg = 64'(msb - 16) * 4096;
        for (int i = 11; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                lg += 64'sd1 << i;
                x >>= 1;
            end
        end
        return sat64(64'(base) + lg);
    endfunction

    function automatic logic signed [63:0] sx16(logic [15:0] v);
        return 64'(signed'(v));
    endfunction

    task automatic start_sequence();
        in_sc = SCORE_START;
        out_sc = SCORE_START;
        foreach (in_hist[k]) in_hist[k] = MINF;
        pos_cnt = 0;
    endtask

    task automatic predict_position(pos_t p);
        score_t t[];
        score_t new_in, new_out;
        logic signed [63:0] bg;
        logic [15:0] ms [4];
        logic [5:0] len;
        logic [5:0] seen;
        int nm;
        t = new[6];
        bg = sx16(p.bg);
        ms = '{p.ms0, p.ms1, p.ms2, p.ms3};
        nm = (n_motifs > 4) ? 4 : n_motifs;
        seen = (pos_cnt < COUNT_MAX) ? pos_cnt + 1 : COUNT_MAX;
        for (int m = 0; m < nm; m++) begin
            len = m_lens[6*m +: 6];
            if (len == 0 || len > 32 || seen < len) t[m] = MINF;
            else t[m] = sum3((len == 1) ? in_sc : in_hist[len - 2], sx16(ms[m]),
                              sx16(m_pens[16*m +: 16]));
        end
        t[nm] = sum3(out_sc, bg, pen_in);
        t[nm + 1] = sum3(in_sc, bg, pen_istay);
        new_in = lse(t, nm + 2);
        t[0] = sum3(out_sc, bg, pen_ostay);
        t[1] = sum3(in_sc, bg, pen_out);
        new_out = lse(t, 2);
        for (int k = 31; k > 0; k--) in_hist[k] = in_hist[k - 1];
        in_hist[0] = in_sc;
        in_sc = new_in;
        out_sc = new_out;
        pos_cnt = seen;
        if (p.last) begin
            t[0] = in_sc;
            t[1] = out_sc;
            likelihood_q.push_back(lse(t, 2));
            start_sequence();
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            REG_CLUSTER_IN:   pen_in = sx16(val[15:0]);
            REG_CLUSTER_OUT:  pen_out = sx16(val[15:0]);
            REG_INSIDE_STAY:  pen_istay = sx16(val[15:0]);
            REG_OUTSIDE_STAY: pen_ostay = sx16(val[15:0]);
            REG_MOTIF_COUNT:  n_motifs = val[2:0];
            REG_MOTIF_PEN:    m_pens = val;
            REG_MOTIF_LEN:    m_lens = val[23:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        s_tvalid <= 0;
        while (likelihood_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic send(pos_t p, logic has_want, logic [31:0] want);
        while (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {p.ms3, p.ms2, p.ms1, p.ms0, p.bg};
        s_tlast <= p.last;
        do @(posedge aclk); while (!s_tready);
        if (p.last) begin
            fixed_has_q.push_back(has_want);
            fixed_q.push_back(want);
        end
        predict_position(p);
    endtask

    function automatic pos_t rand_pos(int last_pct);
        pos_t p;
        p.bg = 16'($urandom);
        if ($urandom_range(3) != 0) p.bg = 16'(-$urandom_range(16384));
        p.ms0 = 16'($urandom);
        p.ms1 = 16'($urandom);
        p.ms2 = 16'($urandom);
        p.ms3 = 16'($urandom);
        p.last = ($urandom_range(99) < last_pct);
        return p;
    endfunction

    task automatic random_config();
        write_reg(REG_CLUSTER_IN, 64'($urandom_range(3) == 0 ? 16'h8000 : -$urandom_range(12000)));
        write_reg(REG_CLUSTER_OUT, 64'(-$urandom_range(32768)));
        write_reg(REG_INSIDE_STAY, 64'(-$urandom_range(4096)));
        write_reg(REG_OUTSIDE_STAY, 64'(-$urandom_range(4096)));
        write_reg(REG_MOTIF_COUNT, 64'($urandom_range(7)));
        write_reg(REG_MOTIF_PEN, {$urandom, $urandom});
        write_reg(REG_MOTIF_LEN, {$urandom_range(2) == 0 ? 6'($urandom) : 6'($urandom_range(1, 8)),
                                  6'($urandom_range(0, 40)), 6'($urandom_range(1, 4)),
                                  6'($urandom_range(1, 3))});
    endtask

    // receiver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) m_tready <= calm || ($urandom_range(99) >= 8);
        if (aresetn && m_tvalid && m_tready) begin
            if (likelihood_q.size() == 0) begin
                $display("%0t: unexpected likelihood %h", $time, m_tdata);
                errors = errors + 1;
            end else begin
                logic [31:0] w;
                w = likelihood_q.pop_front();
                if (fixed_has_q.pop_front()) begin
                    if (fixed_q[0] != w) begin
                        $display("%0t: predictor %h vs table %h", $time, w, fixed_q[0]);
                        errors = errors + 1;
                    end
                end
                void'(fixed_q.pop_front());
                if (m_tdata !== w || m_tuser !== (w == MINF)) begin
                    $display("%0t: expected %h/%0b, got %h/%0b", $time, w, w == MINF,
                             m_tdata, m_tuser);
                    errors = errors + 1;
                end
            end
        end
        if (cycles > 3000000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    row_t rows[$];

    initial begin
        pos_t p;
        n_motifs = 0; m_pens = 0; m_lens = 0;
        pen_in = 0; pen_out = 0; pen_istay = 0; pen_ostay = 0;
        start_sequence();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // defaults: single zero position gives log2(1 + 1) = 1.0
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, 1, 32'h1000});
        // extremes of the emission fields
        rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}, 0, 0});
        rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1}, 0, 0});
        rows.push_back('{'{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1}, 0, 0});
        foreach (rows[i]) send(rows[i].p, rows[i].has_want, rows[i].want);
        rows.delete();
        settle();

        // all motifs, lengths 1 and 3 plus a zero length and an oversize one
        write_reg(REG_MOTIF_COUNT, 64'd7);
        write_reg(REG_MOTIF_PEN, {16'sh8000, 16'sh0000, 16'shF000, 16'shFFFF});
        write_reg(REG_MOTIF_LEN, {6'd33, 6'd0, 6'd3, 6'd1});
        write_reg(3'd7, 64'hFFFF);
        write_reg(REG_CLUSTER_IN, 64'h8000);
        write_reg(REG_CLUSTER_OUT, 64'h8000);
        write_reg(REG_INSIDE_STAY, 64'h8000);
        write_reg(REG_OUTSIDE_STAY, 64'h8000);
        // most negative transition penalties and scores on every path
        for (int i = 0; i < 6; i++)
            rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                               1'(i == 5)}, 0, 0});
        foreach (rows[i]) send(rows[i].p, rows[i].has_want, rows[i].want);
        rows.delete();
        settle();
        write_reg(REG_INSIDE_STAY, 64'h0);
        write_reg(REG_OUTSIDE_STAY, 64'h0);
        // long sequence past the position counter limit
        for (int i = 0; i < 70; i++) begin
            p = rand_pos(0);
            p.last = (i == 69);
            send(p, 0, 0);
        end
        settle();

        for (int phase = 0; phase < 14; phase++) begin
            random_config();
            calm = (phase == 5);
            for (int i = 0; i < 95; i++) send(rand_pos(phase % 3 == 0 ? 3 : 15), 0, 0);
            p = rand_pos(0);
            p.last = 1;
            send(p, 0, 0);
            settle();
        end
        calm = 0;

        while (likelihood_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule
